// File: rtl/core/assert_macros.svh
// assertion helpers shared by the core modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge outside reset
`define ASSERT_ALWAYS(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// condition in one cycle implies a consequence in the next cycle
`define ASSERT_IMPLY_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/fbcpu_pkg.sv
package fbcpu_pkg;

    // field widths
    localparam int NIB_W       = 4;
    localparam int PC_W        = 8;
    localparam int INSTR_W     = 8;

    // stream data widths, padded to whole bytes
    localparam int S_FIELDS_W  = INSTR_W + NIB_W;
    localparam int S_DATA_W    = ((S_FIELDS_W + 7) / 8) * 8;
    localparam int S_PAD_W     = S_DATA_W - S_FIELDS_W;
    localparam int M_FIELDS_W  = PC_W + 3 * NIB_W + 2;
    localparam int M_DATA_W    = ((M_FIELDS_W + 7) / 8) * 8;
    localparam int M_PAD_W     = M_DATA_W - M_FIELDS_W;

    // data ram
    localparam int RAM_DEPTH   = 256;
    localparam int RAM_AW      = $clog2(RAM_DEPTH);

    // decoded instruction queue
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // operation carried out by the back end
    typedef enum logic [3:0] {
        OP_MOVE,
        OP_ADD,
        OP_NEG,
        OP_NOT,
        OP_OR,
        OP_AND,
        OP_XOR,
        OP_SUB,
        OP_STORE_A,
        OP_STORE_B,
        OP_INC_XY,
        OP_JMP_XY,
        OP_JZ,
        OP_JNC,
        OP_JMP
    } op_t;

    // register written by a move or an arithmetic op
    typedef enum logic [2:0] {
        DST_NONE,
        DST_A,
        DST_B,
        DST_OUT,
        DST_X,
        DST_Y
    } dst_t;

    // first operand
    typedef enum logic [2:0] {
        SRC_A,
        SRC_B,
        SRC_PORT,
        SRC_IMM,
        SRC_RAM
    } src_t;

    // decoded instruction
    typedef struct packed {
        op_t              op;
        dst_t             dst;
        src_t             src;
        logic             add_b;
        logic [NIB_W-1:0] imm;
        logic [NIB_W-1:0] port;
    } uop_t;

    // head of the decoded queue as seen by the back end
    typedef struct packed {
        logic valid;
        uop_t uop;
    } q_head_t;

endpackage

// File: rtl/core/fbcpu_ram.sv
module fbcpu_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: rtl/core/fbcpu_front.sv
`include "assert_macros.svh"

module fbcpu_front import fbcpu_pkg::*; (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [S_DATA_W-1:0] s_axis_tdata,   // [7:0] instruction, [11:8] in_port
    output q_head_t             head,
    input  logic                pop
);

    // opcode nibble
    typedef enum logic [3:0] {
        OPC_ADD_A   = 4'h0,
        OPC_MOV_AB  = 4'h1,
        OPC_IN_A    = 4'h2,
        OPC_MOV_AI  = 4'h3,
        OPC_MOV_BA  = 4'h4,
        OPC_ADD_B   = 4'h5,
        OPC_IN_B    = 4'h6,
        OPC_MOV_BI  = 4'h7,
        OPC_GROUP8  = 4'h8,
        OPC_OUT_B   = 4'h9,
        OPC_JZ      = 4'hA,
        OPC_OUT_I   = 4'hB,
        OPC_MOV_YI  = 4'hC,
        OPC_MOV_XI  = 4'hD,
        OPC_JNC     = 4'hE,
        OPC_JMP     = 4'hF
    } opc_t;

    // sub-op of the register group
    typedef enum logic [3:0] {
        SUB_ADD_AB  = 4'h0,
        SUB_NEG     = 4'h1,
        SUB_NOT     = 4'h2,
        SUB_OR      = 4'h3,
        SUB_AND     = 4'h4,
        SUB_XOR     = 4'h5,
        SUB_SUB     = 4'h6,
        SUB_OUT_A   = 4'h7,
        SUB_LD_A    = 4'h8,
        SUB_ST_A    = 4'h9,
        SUB_LD_B    = 4'hA,
        SUB_ST_B    = 4'hB,
        SUB_MOV_XA  = 4'hC,
        SUB_MOV_YA  = 4'hD,
        SUB_INC_XY  = 4'hE,
        SUB_JMP_XY  = 4'hF
    } sub_t;

    logic [INSTR_W-1:0] instr;
    logic [NIB_W-1:0]   imm;
    logic               imm_zero;
    uop_t               dec;
    logic               push;

    uop_t               q_mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg;
    logic [QPTR_W-1:0]  wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg;
    logic [QPTR_W-1:0]  rd_ptr_next;
    logic [QCNT_W-1:0]  count_reg;
    logic [QCNT_W-1:0]  count_next;

    assign instr    = s_axis_tdata[INSTR_W-1:0];
    assign imm      = instr[NIB_W-1:0];
    assign imm_zero = (imm == '0);

    // classify the instruction
    always_comb
    begin
        dec.op    = OP_MOVE;
        dec.dst   = DST_NONE;
        dec.src   = SRC_IMM;
        dec.add_b = 1'b0;
        dec.imm   = imm;
        dec.port  = s_axis_tdata[INSTR_W +: NIB_W];
        case (opc_t'(instr[INSTR_W-1 -: NIB_W]))
            OPC_ADD_A:
            begin
                dec.op  = OP_ADD;
                dec.dst = DST_A;
                dec.src = SRC_A;
            end
            OPC_MOV_AB:
            begin
                dec.op  = imm_zero ? OP_MOVE : OP_ADD;
                dec.dst = DST_A;
                dec.src = SRC_B;
            end
            OPC_IN_A:
            begin
                dec.op  = imm_zero ? OP_MOVE : OP_ADD;
                dec.dst = DST_A;
                dec.src = SRC_PORT;
            end
            OPC_MOV_AI:
            begin
                dec.dst = DST_A;
            end
            OPC_MOV_BA:
            begin
                dec.op  = imm_zero ? OP_MOVE : OP_ADD;
                dec.dst = DST_B;
                dec.src = SRC_A;
            end
            OPC_ADD_B:
            begin
                dec.op  = OP_ADD;
                dec.dst = DST_B;
                dec.src = SRC_B;
            end
            OPC_IN_B:
            begin
                dec.op  = imm_zero ? OP_MOVE : OP_ADD;
                dec.dst = DST_B;
                dec.src = SRC_PORT;
            end
            OPC_MOV_BI:
            begin
                dec.dst = DST_B;
            end
            OPC_GROUP8:
            begin
                dec.dst = DST_A;
                dec.src = SRC_A;
                case (sub_t'(imm))
                    SUB_ADD_AB:
                    begin
                        dec.op    = OP_ADD;
                        dec.add_b = 1'b1;
                    end
                    SUB_NEG:    dec.op = OP_NEG;
                    SUB_NOT:    dec.op = OP_NOT;
                    SUB_OR:     dec.op = OP_OR;
                    SUB_AND:    dec.op = OP_AND;
                    SUB_XOR:    dec.op = OP_XOR;
                    SUB_SUB:    dec.op = OP_SUB;
                    SUB_OUT_A:  dec.dst = DST_OUT;
                    SUB_LD_A:   dec.src = SRC_RAM;
                    SUB_ST_A:
                    begin
                        dec.op  = OP_STORE_A;
                        dec.dst = DST_NONE;
                    end
                    SUB_LD_B:
                    begin
                        dec.dst = DST_B;
                        dec.src = SRC_RAM;
                    end
                    SUB_ST_B:
                    begin
                        dec.op  = OP_STORE_B;
                        dec.dst = DST_NONE;
                    end
                    SUB_MOV_XA: dec.dst = DST_X;
                    SUB_MOV_YA: dec.dst = DST_Y;
                    SUB_INC_XY:
                    begin
                        dec.op  = OP_INC_XY;
                        dec.dst = DST_NONE;
                    end
                    SUB_JMP_XY:
                    begin
                        dec.op  = OP_JMP_XY;
                        dec.dst = DST_NONE;
                    end
                    default:    dec.op = OP_MOVE;
                endcase
            end
            OPC_OUT_B:
            begin
                dec.op  = imm_zero ? OP_MOVE : OP_ADD;
                dec.dst = DST_OUT;
                dec.src = SRC_B;
            end
            OPC_JZ:     dec.op = OP_JZ;
            OPC_OUT_I:  dec.dst = DST_OUT;
            OPC_MOV_YI: dec.dst = DST_Y;
            OPC_MOV_XI: dec.dst = DST_X;
            OPC_JNC:    dec.op = OP_JNC;
            OPC_JMP:    dec.op = OP_JMP;
            default:    dec.op = OP_JMP;
        endcase
    end

    // queue control
    assign s_axis_tready = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign push          = s_axis_tvalid && s_axis_tready;
    assign head.valid    = (count_reg != '0);
    assign head.uop      = q_mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                   : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                   : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // queue storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem_reg[wr_ptr_reg] <= dec;
        end
    end

    `ASSERT_ALWAYS(a_count_bound, count_reg <= QCNT_W'(QUEUE_DEPTH), "queue overfilled")
    `ASSERT_IMPLY_NEXT(a_push_grows, push && !pop, count_reg == $past(count_reg) + 1'b1, "push lost")
    `ASSERT_ALWAYS(a_pop_nonempty, !pop || head.valid, "pop from empty queue")

endmodule

// File: rtl/core/fbcpu_back.sv
`include "assert_macros.svh"

module fbcpu_back import fbcpu_pkg::*; (
    input  logic                clk,
    input  logic                rst_n,
    input  q_head_t             head,
    output logic                pop,
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [M_DATA_W-1:0] m_axis_tdata
);

    // architectural state
    logic [NIB_W-1:0]  a_reg, a_next;
    logic [NIB_W-1:0]  b_reg, b_next;
    logic [NIB_W-1:0]  x_reg, x_next;
    logic [NIB_W-1:0]  y_reg, y_next;
    logic              carry_reg, carry_next;
    logic              zero_reg, zero_next;
    logic [PC_W-1:0]   pc_reg, pc_next;
    logic [NIB_W-1:0]  outl_reg, outl_next;

    // data ram with per-entry valid bits and write bypass
    logic [RAM_DEPTH-1:0] valid_reg;
    logic                 rd_valid_reg;
    logic                 byp_reg;
    logic [NIB_W-1:0]     byp_data_reg;
    logic [RAM_AW-1:0]    ram_waddr;
    logic [RAM_AW-1:0]    ram_raddr;
    logic [NIB_W-1:0]     ram_wdata;
    logic [NIB_W-1:0]     ram_rdata;
    logic                 ram_we;
    logic [NIB_W-1:0]     ram_val;

    // result register
    logic              out_valid_reg;
    logic [PC_W-1:0]   o_pc_reg;
    logic [NIB_W-1:0]  o_outl_reg;
    logic [NIB_W-1:0]  o_a_reg;
    logic [NIB_W-1:0]  o_b_reg;
    logic              o_carry_reg;
    logic              o_zero_reg;

    uop_t              uop;
    logic              out_ready;
    logic              fire;
    logic [NIB_W-1:0]  src_val;
    logic [NIB_W-1:0]  addend;
    logic [NIB_W:0]    sum;
    logic [NIB_W:0]    diff;
    logic [RAM_AW-1:0] xy_inc;
    logic [PC_W-1:0]   page;
    logic [NIB_W-1:0]  res;
    logic              res_we;

    assign uop       = head.uop;
    assign out_ready = !out_valid_reg || m_axis_tready;
    assign fire      = head.valid && out_ready;
    assign pop       = fire;

    // operands
    always_comb
    begin
        case (uop.src)
            SRC_A:    src_val = a_reg;
            SRC_B:    src_val = b_reg;
            SRC_PORT: src_val = uop.port;
            SRC_IMM:  src_val = uop.imm;
            SRC_RAM:  src_val = ram_val;
            default:  src_val = uop.imm;
        endcase
    end

    assign addend = uop.add_b ? b_reg : uop.imm;
    assign sum    = {1'b0, src_val} + {1'b0, addend};
    assign diff   = {1'b0, a_reg} - {1'b0, b_reg};
    assign xy_inc = {x_reg, y_reg} + 1'b1;
    assign page   = {pc_reg[PC_W-1:NIB_W], uop.imm};

    // execute
    always_comb
    begin
        a_next     = a_reg;
        b_next     = b_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        carry_next = carry_reg;
        zero_next  = zero_reg;
        pc_next    = pc_reg;
        outl_next  = outl_reg;
        ram_we     = 1'b0;
        ram_wdata  = a_reg;
        res        = src_val;
        res_we     = 1'b1;
        if (fire)
        begin
            pc_next    = pc_reg + 1'b1;
            carry_next = 1'b0;
            zero_next  = 1'b0;
            case (uop.op)
                OP_MOVE: res = src_val;
                OP_ADD:
                begin
                    res        = sum[NIB_W-1:0];
                    carry_next = sum[NIB_W];
                    zero_next  = (sum[NIB_W-1:0] == '0);
                end
                OP_NEG:
                begin
                    res        = '0 - a_reg;
                    res_we     = (a_reg != '0);
                    carry_next = (a_reg == '0);
                end
                OP_NOT:
                begin
                    res       = ~a_reg;
                    zero_next = (res == '0);
                end
                OP_OR:
                begin
                    res       = a_reg | b_reg;
                    zero_next = (res == '0);
                end
                OP_AND:
                begin
                    res       = a_reg & b_reg;
                    zero_next = (res == '0);
                end
                OP_XOR:
                begin
                    res       = a_reg ^ b_reg;
                    zero_next = (res == '0);
                end
                OP_SUB:
                begin
                    res        = diff[NIB_W-1:0];
                    carry_next = diff[NIB_W];
                    zero_next  = !diff[NIB_W] && (diff[NIB_W-1:0] == '0);
                end
                OP_STORE_A:
                begin
                    ram_we    = 1'b1;
                    ram_wdata = a_reg;
                end
                OP_STORE_B:
                begin
                    ram_we    = 1'b1;
                    ram_wdata = b_reg;
                end
                OP_INC_XY:
                begin
                    x_next = xy_inc[RAM_AW-1:NIB_W];
                    y_next = xy_inc[NIB_W-1:0];
                end
                OP_JMP_XY:
                begin
                    pc_next    = {x_reg, y_reg};
                    carry_next = carry_reg;
                    zero_next  = zero_reg;
                end
                OP_JZ:
                begin
                    if (zero_reg)
                    begin
                        pc_next = page;
                    end
                    carry_next = carry_reg;
                    zero_next  = zero_reg;
                end
                OP_JNC:
                begin
                    if (!carry_reg)
                    begin
                        pc_next = page;
                    end
                    carry_next = carry_reg;
                    zero_next  = zero_reg;
                end
                OP_JMP:
                begin
                    pc_next    = page;
                    carry_next = carry_reg;
                    zero_next  = zero_reg;
                end
                default: res_we = 1'b0;
            endcase
            if (res_we)
            begin
                case (uop.dst)
                    DST_A:    a_next    = res;
                    DST_B:    b_next    = res;
                    DST_OUT:  outl_next = res;
                    DST_X:    x_next    = res;
                    DST_Y:    y_next    = res;
                    default:  a_next    = a_reg;
                endcase
            end
        end
    end

    // ram is read ahead at the xy address the next instruction sees
    assign ram_waddr = {x_reg, y_reg};
    assign ram_raddr = {x_next, y_next};
    assign ram_val   = byp_reg ? byp_data_reg : (rd_valid_reg ? ram_rdata : '0);

    fbcpu_ram #(
        .WIDTH (NIB_W),
        .DEPTH (RAM_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // state, valid bits and bypass
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_reg         <= '0;
            b_reg         <= '0;
            x_reg         <= '0;
            y_reg         <= '0;
            carry_reg     <= 1'b0;
            zero_reg      <= 1'b0;
            pc_reg        <= '0;
            outl_reg      <= '0;
            valid_reg     <= '0;
            rd_valid_reg  <= 1'b0;
            byp_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            a_reg        <= a_next;
            b_reg        <= b_next;
            x_reg        <= x_next;
            y_reg        <= y_next;
            carry_reg    <= carry_next;
            zero_reg     <= zero_next;
            pc_reg       <= pc_next;
            outl_reg     <= outl_next;
            rd_valid_reg <= valid_reg[ram_raddr];
            byp_reg      <= ram_we && (ram_waddr == ram_raddr);
            if (ram_we)
            begin
                valid_reg[ram_waddr] <= 1'b1;
            end
            if (out_ready)
            begin
                out_valid_reg <= fire;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        byp_data_reg <= ram_wdata;
        if (fire)
        begin
            o_pc_reg    <= pc_next;
            o_outl_reg  <= outl_next;
            o_a_reg     <= a_next;
            o_b_reg     <= b_next;
            o_carry_reg <= carry_next;
            o_zero_reg  <= zero_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{M_PAD_W{1'b0}}, o_zero_reg, o_carry_reg, o_b_reg, o_a_reg,
                            o_outl_reg, o_pc_reg};

    `ASSERT_IMPLY_NEXT(a_fire_loads_out, fire, out_valid_reg, "executed beat not presented")
    `ASSERT_IMPLY_NEXT(a_jump_keeps_flags, fire && (uop.op == OP_JZ || uop.op == OP_JNC || uop.op == OP_JMP || uop.op == OP_JMP_XY), carry_reg == $past(carry_reg) && zero_reg == $past(zero_reg), "jump changed flags")
    `ASSERT_IMPLY_NEXT(a_store_bypass, fire && (uop.op == OP_STORE_A || uop.op == OP_STORE_B), ram_val == $past(ram_wdata), "stored nibble not visible")

endmodule

// File: rtl/core/four_bit_cpu_execute.sv
// channel  | dir | handshake                     | beat contents (low bit first)
// ---------+-----+-------------------------------+----------------------------------------
// s_axis   | in  | s_axis_tvalid / s_axis_tready | instruction[7:0], in_port[11:8]
// m_axis   | out | m_axis_tvalid / m_axis_tready | next_pc[7:0], out_port[11:8],
//          |     |                               | reg_a[15:12], reg_b[19:16], carry[20], zero[21]
//
// one instruction retires per clock unless the queue is empty or the output stalls
// a result beat passes the decode queue and then the result register before it is shown
// (queue write at the accepting edge, result register load when the beat executes)
// a two-entry decode queue and the result register let either side stall alone
// data ram read is registered and addressed ahead with the next x/y, plus a write bypass
// reset clears state and pointer registers and ram valid bits at once; no clearing pass is needed
module four_bit_cpu_execute import fbcpu_pkg::*; (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [S_DATA_W-1:0] s_axis_tdata,   // instruction, in_port, zero pad
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [M_DATA_W-1:0] m_axis_tdata    // next_pc, out_port, reg_a_value,
                                                // reg_b_value, carry_out, zero_out, zero pad
);

    q_head_t head;
    logic    pop;

    // decode and queue
    fbcpu_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .head          (head),
        .pop           (pop)
    );

    // execute and result register
    fbcpu_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .head          (head),
        .pop           (pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule

// File: test/tb_four_bit_cpu_execute.sv
`timescale 1ns / 1ps

module tb_four_bit_cpu_execute import fbcpu_pkg::*;;

    localparam int RAND_ITEMS = 1550;
    localparam int PLAN_ROWS  = 42;
    localparam int HOLD_BEAT  = 250;
    localparam int HOLD_LEN   = 80;

    // opcode in the upper nibble of the instruction
    typedef enum logic [3:0] {
        OPC_ADD_A  = 4'h0,
        OPC_MOV_AB = 4'h1,
        OPC_IN_A   = 4'h2,
        OPC_MOV_AI = 4'h3,
        OPC_MOV_BA = 4'h4,
        OPC_ADD_B  = 4'h5,
        OPC_IN_B   = 4'h6,
        OPC_MOV_BI = 4'h7,
        OPC_GROUP  = 4'h8,
        OPC_OUT_B  = 4'h9,
        OPC_JZ     = 4'hA,
        OPC_OUT_I  = 4'hB,
        OPC_MOV_YI = 4'hC,
        OPC_MOV_XI = 4'hD,
        OPC_JNC    = 4'hE,
        OPC_JMP    = 4'hF
    } opcode_t;

    // register and memory ops selected by the low nibble of group 8
    typedef enum logic [3:0] {
        GRP_ADD_AB = 4'h0,
        GRP_NEG    = 4'h1,
        GRP_NOT    = 4'h2,
        GRP_OR     = 4'h3,
        GRP_AND    = 4'h4,
        GRP_XOR    = 4'h5,
        GRP_SUB    = 4'h6,
        GRP_OUT_A  = 4'h7,
        GRP_LD_A   = 4'h8,
        GRP_ST_A   = 4'h9,
        GRP_LD_B   = 4'hA,
        GRP_ST_B   = 4'hB,
        GRP_MOV_XA = 4'hC,
        GRP_MOV_YA = 4'hD,
        GRP_INC_XY = 4'hE,
        GRP_JMP_XY = 4'hF
    } group_t;

    // machine state visible after one instruction
    typedef struct packed {
        logic [7:0] next_pc;
        logic [3:0] out_port;
        logic [3:0] reg_a_value;
        logic [3:0] reg_b_value;
        logic       carry_out;
        logic       zero_out;
    } cpu_view_t;

    // one directed row: instruction, port, and a typed view where given
    typedef struct packed {
        logic [7:0] instr;
        logic [3:0] port;
        logic       typed;
        cpu_view_t  view;
    } plan_row_t;

    localparam plan_row_t PLAN [PLAN_ROWS] = '{
        '{8'h00, 4'h0, 1'b1, '{8'h01, 4'h0, 4'h0, 4'h0, 1'b0, 1'b1}},
        '{8'h0F, 4'h0, 1'b1, '{8'h02, 4'h0, 4'hF, 4'h0, 1'b0, 1'b0}},
        '{8'h01, 4'h0, 1'b1, '{8'h03, 4'h0, 4'h0, 4'h0, 1'b1, 1'b1}},
        '{8'hE7, 4'h0, 1'b1, '{8'h04, 4'h0, 4'h0, 4'h0, 1'b1, 1'b1}},
        '{8'hA9, 4'h0, 1'b1, '{8'h09, 4'h0, 4'h0, 4'h0, 1'b1, 1'b1}},
        '{8'h2F, 4'hF, 1'b0, '0},
        '{8'h20, 4'hA, 1'b0, '0},
        '{8'h60, 4'h5, 1'b0, '0},
        '{8'h6F, 4'h0, 1'b0, '0},
        '{8'h3F, 4'h0, 1'b0, '0},
        '{8'h7F, 4'h0, 1'b0, '0},
        '{8'h80, 4'h0, 1'b0, '0},
        '{8'h81, 4'h0, 1'b0, '0},
        '{8'h30, 4'h0, 1'b0, '0},
        '{8'h81, 4'h0, 1'b0, '0},
        '{8'h82, 4'h0, 1'b0, '0},
        '{8'h83, 4'h0, 1'b0, '0},
        '{8'h84, 4'h0, 1'b0, '0},
        '{8'h85, 4'h0, 1'b0, '0},
        '{8'h86, 4'h0, 1'b0, '0},
        '{8'h87, 4'h0, 1'b0, '0},
        '{8'h10, 4'h0, 1'b0, '0},
        '{8'h1F, 4'h0, 1'b0, '0},
        '{8'h40, 4'h0, 1'b0, '0},
        '{8'h4F, 4'h0, 1'b0, '0},
        '{8'h5F, 4'h0, 1'b0, '0},
        '{8'h90, 4'h0, 1'b0, '0},
        '{8'h9F, 4'h0, 1'b0, '0},
        '{8'hBF, 4'h0, 1'b0, '0},
        '{8'hDF, 4'h0, 1'b0, '0},
        '{8'hCF, 4'h0, 1'b0, '0},
        '{8'h8F, 4'h0, 1'b0, '0},
        '{8'h89, 4'h0, 1'b0, '0},
        '{8'h8E, 4'h0, 1'b0, '0},
        '{8'h8B, 4'h0, 1'b0, '0},
        '{8'h8A, 4'h0, 1'b0, '0},
        '{8'h88, 4'h0, 1'b0, '0},
        '{8'h8C, 4'h0, 1'b0, '0},
        '{8'h8D, 4'h0, 1'b0, '0},
        '{8'hA2, 4'h0, 1'b0, '0},
        '{8'hE5, 4'h0, 1'b0, '0},
        '{8'hF3, 4'h0, 1'b0, '0}
    };

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [S_DATA_W-1:0] s_axis_tdata = '0;   // instruction, in_port, zero pad
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [M_DATA_W-1:0] m_axis_tdata;        // next_pc, out_port, reg_a_value,
                                              // reg_b_value, carry_out, zero_out, zero pad

    // shadow copy of the cpu state
    logic [3:0] acc_a, acc_b, idx_x, idx_y;
    logic       carry_st, zero_st;
    logic [7:0] pc_st;
    logic [3:0] latch_st;
    logic [3:0] ram_st [RAM_DEPTH];

    cpu_view_t   views_due [$];
    int unsigned mismatch_count = 0;

    four_bit_cpu_execute DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // 8 ns clock
    always #4 clk = ~clk;

    // 4-bit add that sets carry and zero
    function automatic logic [3:0] add_nibbles(input logic [3:0] p, input logic [3:0] q);
        logic [4:0] sum;
        sum      = {1'b0, p} + {1'b0, q};
        carry_st = sum[4];
        zero_st  = (sum[3:0] == 4'd0);
        return sum[3:0];
    endfunction

    // plain move: both flags cleared
    function automatic logic [3:0] moved(input logic [3:0] v);
        carry_st = 1'b0;
        zero_st  = 1'b0;
        return v;
    endfunction

    // logic result: carry cleared, zero from the value
    function automatic logic [3:0] logic_result(input logic [3:0] v);
        carry_st = 1'b0;
        zero_st  = (v == 4'd0);
        return v;
    endfunction

    // execute one instruction on the shadow state and return the new view
    function automatic cpu_view_t execute_instr(input logic [7:0] instr,
                                                input logic [3:0] port);
        logic [3:0] imm;
        logic [7:0] npc, xy;
        cpu_view_t  v;
        imm = instr[3:0];
        npc = pc_st + 8'd1;
        xy  = {idx_x, idx_y};
        case (opcode_t'(instr[7:4]))
            OPC_ADD_A:  acc_a = add_nibbles(acc_a, imm);
            OPC_MOV_AB:
                if (imm == 4'd0)
                    acc_a = moved(acc_b);
                else
                    acc_a = add_nibbles(acc_b, imm);
            OPC_IN_A:
                if (imm == 4'd0)
                    acc_a = moved(port);
                else
                    acc_a = add_nibbles(port, imm);
            OPC_MOV_AI: acc_a = moved(imm);
            OPC_MOV_BA:
                if (imm == 4'd0)
                    acc_b = moved(acc_a);
                else
                    acc_b = add_nibbles(acc_a, imm);
            OPC_ADD_B:  acc_b = add_nibbles(acc_b, imm);
            OPC_IN_B:
                if (imm == 4'd0)
                    acc_b = moved(port);
                else
                    acc_b = add_nibbles(port, imm);
            OPC_MOV_BI: acc_b = moved(imm);
            OPC_GROUP:
            begin
                // logic ops clear carry and set zero from A
                case (group_t'(imm))
                    GRP_ADD_AB: acc_a = add_nibbles(acc_a, acc_b);
                    GRP_NEG:
                        if (acc_a == 4'd0)
                        begin
                            carry_st = 1'b1;
                            zero_st  = 1'b0;
                        end
                        else
                            acc_a = moved(4'd0 - acc_a);
                    GRP_NOT:    acc_a = logic_result(~acc_a);
                    GRP_OR:     acc_a = logic_result(acc_a | acc_b);
                    GRP_AND:    acc_a = logic_result(acc_a & acc_b);
                    GRP_XOR:    acc_a = logic_result(acc_a ^ acc_b);
                    GRP_SUB:
                        if (acc_a < acc_b)
                        begin
                            acc_a    = acc_a - acc_b;
                            carry_st = 1'b1;
                            zero_st  = 1'b0;
                        end
                        else
                            acc_a = logic_result(acc_a - acc_b);
                    GRP_OUT_A:  latch_st = moved(acc_a);
                    GRP_LD_A:   acc_a = moved(ram_st[xy]);
                    GRP_ST_A:   ram_st[xy] = moved(acc_a);
                    GRP_LD_B:   acc_b = moved(ram_st[xy]);
                    GRP_ST_B:   ram_st[xy] = moved(acc_b);
                    GRP_MOV_XA: idx_x = moved(acc_a);
                    GRP_MOV_YA: idx_y = moved(acc_a);
                    GRP_INC_XY:
                    begin
                        {idx_x, idx_y} = xy + 8'd1;
                        carry_st       = 1'b0;
                        zero_st        = 1'b0;
                    end
                    GRP_JMP_XY: npc = xy;
                    default: ;
                endcase
            end
            OPC_OUT_B:
                if (imm == 4'd0)
                    latch_st = moved(acc_b);
                else
                    latch_st = add_nibbles(acc_b, imm);
            OPC_JZ:     if (zero_st) npc = {pc_st[7:4], imm};
            OPC_OUT_I:  latch_st = moved(imm);
            OPC_MOV_YI: idx_y = moved(imm);
            OPC_MOV_XI: idx_x = moved(imm);
            OPC_JNC:    if (!carry_st) npc = {pc_st[7:4], imm};
            default:    npc = {pc_st[7:4], imm};
        endcase
        pc_st = npc;
        v = '{pc_st, latch_st, acc_a, acc_b, carry_st, zero_st};
        return v;
    endfunction

    // one line per mismatch
    task automatic report_mismatch(input string what, input int got, input int want);
        $display("[%0t] mismatch %s: got %0h expected %0h", $realtime, what, got, want);
        mismatch_count++;
    endtask

    // offer one beat after a random gap (none when no_gap is set), predict on acceptance
    task automatic send_beat(input logic [7:0] instr, input logic [3:0] port,
                             input logic typed, input cpu_view_t view, input bit no_gap);
        int unsigned gap;
        cpu_view_t   predicted;
        gap = no_gap ? 0 : $urandom_range(0, 4);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{S_PAD_W{1'b0}}, port, instr};
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        predicted = execute_instr(instr, port);
        views_due.push_back(typed ? view : predicted);
    endtask

    // receiver: random stalls, one long hold-off, and a stretch with none
    initial
    begin
        int unsigned beats;
        int unsigned gap;
        beats = 0;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever
        begin
            if (beats == HOLD_BEAT)
                gap = HOLD_LEN;
            else if (beats >= 900 && beats < 1100)
                gap = 0;
            else
                gap = $urandom_range(0, 4);
            if (gap > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge clk);
            while (!m_axis_tvalid) @(posedge clk);
            beats++;
        end
    end

    // compare every result beat with the oldest predicted view
    always @(posedge clk)
    begin
        cpu_view_t got, want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = '{m_axis_tdata[7:0], m_axis_tdata[11:8], m_axis_tdata[15:12],
                    m_axis_tdata[19:16], m_axis_tdata[20], m_axis_tdata[21]};
            if (views_due.size() == 0)
                report_mismatch("unexpected beat", int'(got), 0);
            else
            begin
                want = views_due.pop_front();
                if (got.next_pc != want.next_pc)
                    report_mismatch("next_pc", got.next_pc, want.next_pc);
                if (got.out_port != want.out_port)
                    report_mismatch("out_port", got.out_port, want.out_port);
                if (got.reg_a_value != want.reg_a_value)
                    report_mismatch("reg_a_value", got.reg_a_value, want.reg_a_value);
                if (got.reg_b_value != want.reg_b_value)
                    report_mismatch("reg_b_value", got.reg_b_value, want.reg_b_value);
                if (got.carry_out != want.carry_out)
                    report_mismatch("carry_out", got.carry_out, want.carry_out);
                if (got.zero_out != want.zero_out)
                    report_mismatch("zero_out", got.zero_out, want.zero_out);
            end
        end
    end

    // watchdog
    initial
    begin
        #2_000_000;
        $display("four_bit_cpu_execute regression: fail");
        $finish;
    end

    // reset, directed table, random instruction stream, drain
    initial
    begin
        logic [7:0]  instr;
        int unsigned pick;
        acc_a    = 4'd0;
        acc_b    = 4'd0;
        idx_x    = 4'd0;
        idx_y    = 4'd0;
        carry_st = 1'b0;
        zero_st  = 1'b0;
        pc_st    = 8'd0;
        latch_st = 4'd0;
        for (int i = 0; i < RAM_DEPTH; i++)
            ram_st[i] = 4'd0;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed rows
        for (int r = 0; r < PLAN_ROWS; r++)
            send_beat(PLAN[r].instr, PLAN[r].port, PLAN[r].typed, PLAN[r].view, 1'b0);

        // random rows, biased toward the register/memory group and a small ram window
        for (int n = 0; n < RAND_ITEMS; n++)
        begin
            pick  = $urandom_range(0, 9);
            instr = 8'($urandom_range(0, 255));
            if (pick < 3)
                instr[7:4] = OPC_GROUP;
            else if (pick == 3)
                instr = {OPC_MOV_XI, 3'b000, 1'($urandom_range(0, 1))};
            send_beat(instr, 4'($urandom_range(0, 15)), 1'b0, '0, (n >= 600 && n < 800));
        end
        s_axis_tvalid <= 1'b0;

        // drain
        while (views_due.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
        if (mismatch_count == 0)
            $display("four_bit_cpu_execute regression: pass");
        else
            $display("four_bit_cpu_execute regression: fail");
        $finish;
    end

endmodule

// File: sim.f
+incdir+rtl/core
rtl/core/fbcpu_pkg.sv
rtl/core/fbcpu_ram.sv
rtl/core/fbcpu_front.sv
rtl/core/fbcpu_back.sv
rtl/core/four_bit_cpu_execute.sv
test/tb_four_bit_cpu_execute.sv
